// ----- src/stoch_vol_path_call_payoff_assert.svh -----
// assertion macros for the path payoff engine
`ifndef STOCH_VOL_PATH_CALL_PAYOFF_ASSERT_SVH
`define STOCH_VOL_PATH_CALL_PAYOFF_ASSERT_SVH
`ifndef SYNTH
`define SVPC_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);
`define SVPC_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);
`else
`define SVPC_ASSERT_IMP(lbl, clk, rstn, pre, post, msg)
`define SVPC_ASSERT_NXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ----- src/svpc_pkg.sv -----
// shared types, constants and helpers of the path payoff engine
package svpc_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int NORMAL_FRAC_BITS = 12;

  localparam int WORD_W     = 32;
  localparam int NORM_W     = 16;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int ACC_W      = WORD_W + 2;
  localparam int STEP_W     = 16;
  localparam int SUM_W      = 48;
  localparam int PAY_W      = WORD_W - 1;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int OPC_W      = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t WORD_ONE = word_t'(1 << FRAC_BITS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_PRICE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VOL_MEAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_COEF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_COEF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_NOISE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_COEF    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS        = 3'd7;

  // product issue order on the shared multiplier
  localparam logic [OPC_W-1:0] OP_SV     = 4'd0;
  localparam logic [OPC_W-1:0] OP_SR     = 4'd1;
  localparam logic [OPC_W-1:0] OP_TSQ    = 4'd2;
  localparam logic [OPC_W-1:0] OP_ADV    = 4'd3;
  localparam logic [OPC_W-1:0] OP_TN1    = 4'd4;
  localparam logic [OPC_W-1:0] OP_KRHO   = 4'd5;
  localparam logic [OPC_W-1:0] OP_KNOISE = 4'd6;
  localparam logic [OPC_W-1:0] OP_A0DM   = 4'd7;
  localparam logic [OPC_W-1:0] OP_K0N3   = 4'd8;
  localparam logic [OPC_W-1:0] RUN_LAST  = 4'd9;
  localparam logic [OPC_W-1:0] OPC_ONE   = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_UPDATE,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic              in_ready;
    logic              load_en;
    logic              run_en;
    logic              update_en;
    logic              finish_en;
    logic [OPC_W-1:0]  op_cnt;
  } seq_ctl_t;

  typedef struct packed {
    word_t a;
    word_t b;
    logic  norm;
  } mul_req_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_res_t;

  typedef struct packed {
    word_t             init_price;
    word_t             init_vol;
    word_t             init_mean;
    word_t             strike;
    word_t             rdt;
    word_t             sqdt;
    word_t             adt;
    word_t             krho;
    word_t             knoise;
    word_t             mtarget;
    word_t             a0dt;
    word_t             k0sdt;
    logic [STEP_W-1:0] steps;
  } cfg_t;

  function automatic acc_t word_to_acc(input word_t w);
    return {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
  endfunction

  function automatic word_t norm_to_word(input norm_t n);
    return {{(WORD_W-NORM_W){n[NORM_W-1]}}, n};
  endfunction

  function automatic sat_res_t sat_acc(input acc_t x);
    sat_res_t r;
    logic [ACC_W-WORD_W:0] hi;
    hi    = x[ACC_W-1:WORD_W-1];
    r.ovf = !((&hi) || (~|hi));
    if (r.ovf) begin
      r.val = x[ACC_W-1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.val = x[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/svpc_if.sv -----
// item channels of the path payoff engine
interface svpc_in_if;
  logic                 valid;
  logic                 ready;
  svpc_pkg::norm_t      normal_price;
  svpc_pkg::norm_t      normal_vol;
  svpc_pkg::norm_t      normal_mean;

  modport source (output valid, normal_price, normal_vol, normal_mean, input ready);
  modport sink   (input valid, normal_price, normal_vol, normal_mean, output ready);
endinterface

interface svpc_out_if;
  logic                            valid;
  logic                            ready;
  logic [svpc_pkg::PAY_W-1:0]      path_payoff;
  logic [svpc_pkg::SUM_W-1:0]      payoff_total;
  logic [svpc_pkg::CNT_W-1:0]      paths_done;
  logic                            overflow_seen;

  modport source (output valid, path_payoff, payoff_total, paths_done, overflow_seen,
                  input ready);
  modport sink   (input valid, path_payoff, payoff_total, paths_done, overflow_seen,
                  output ready);
endinterface

// ----- src/svpc_cfg_regs.sv -----
// configuration register file
module svpc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [svpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [svpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output svpc_pkg::cfg_t                   cfg_o
);

  logic [svpc_pkg::WORD_W-1:0]     price_q;
  logic [svpc_pkg::WORD_W-1:0]     strike_q;
  logic [svpc_pkg::CFG_DATA_W-1:0] vm_q;
  logic [svpc_pkg::CFG_DATA_W-1:0] pc_q;
  logic [svpc_pkg::CFG_DATA_W-1:0] vc_q;
  logic [svpc_pkg::CFG_DATA_W-1:0] vn_q;
  logic [svpc_pkg::CFG_DATA_W-1:0] mc_q;
  logic [svpc_pkg::STEP_W-1:0]     steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_q  <= svpc_pkg::WORD_ONE;
      strike_q <= svpc_pkg::WORD_ONE;
      vm_q     <= '0;
      pc_q     <= '0;
      vc_q     <= '0;
      vn_q     <= '0;
      mc_q     <= '0;
      steps_q  <= svpc_pkg::STEP_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        svpc_pkg::REG_INIT_PRICE:    price_q  <= cfg_data_i[svpc_pkg::WORD_W-1:0];
        svpc_pkg::REG_INIT_VOL_MEAN: vm_q     <= cfg_data_i;
        svpc_pkg::REG_STRIKE:        strike_q <= cfg_data_i[svpc_pkg::WORD_W-1:0];
        svpc_pkg::REG_PRICE_COEF:    pc_q     <= cfg_data_i;
        svpc_pkg::REG_VOL_COEF:      vc_q     <= cfg_data_i;
        svpc_pkg::REG_VOL_NOISE:     vn_q     <= cfg_data_i;
        svpc_pkg::REG_MEAN_COEF:     mc_q     <= cfg_data_i;
        svpc_pkg::REG_STEPS:         steps_q  <= cfg_data_i[svpc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // split 64-bit registers into high and low words
  assign cfg_o.init_price = price_q;
  assign cfg_o.init_vol   = vm_q[svpc_pkg::CFG_DATA_W-1:svpc_pkg::WORD_W];
  assign cfg_o.init_mean  = vm_q[svpc_pkg::WORD_W-1:0];
  assign cfg_o.strike     = strike_q;
  assign cfg_o.rdt        = pc_q[svpc_pkg::CFG_DATA_W-1:svpc_pkg::WORD_W];
  assign cfg_o.sqdt       = pc_q[svpc_pkg::WORD_W-1:0];
  assign cfg_o.adt        = vc_q[svpc_pkg::CFG_DATA_W-1:svpc_pkg::WORD_W];
  assign cfg_o.krho       = vc_q[svpc_pkg::WORD_W-1:0];
  assign cfg_o.knoise     = vn_q[svpc_pkg::CFG_DATA_W-1:svpc_pkg::WORD_W];
  assign cfg_o.mtarget    = vn_q[svpc_pkg::WORD_W-1:0];
  assign cfg_o.a0dt       = mc_q[svpc_pkg::CFG_DATA_W-1:svpc_pkg::WORD_W];
  assign cfg_o.k0sdt      = mc_q[svpc_pkg::WORD_W-1:0];
  assign cfg_o.steps      = steps_q;

endmodule

// ----- src/svpc_mul_unit.sv -----
// shared fixed-point multiplier with floor shift and saturation
module svpc_mul_unit (
  input  logic               clk_i,
  input  svpc_pkg::mul_req_t req_i,
  output svpc_pkg::sat_res_t res_o
);

  logic signed [svpc_pkg::PROD_W-1:0]                 prod_q;
  logic                                               norm_q;
  logic signed [svpc_pkg::PROD_W-1:0]                 shifted;
  logic        [svpc_pkg::PROD_W-svpc_pkg::WORD_W:0]  hi;

  always_ff @(posedge clk_i) begin
    prod_q <= svpc_pkg::PROD_W'($signed(req_i.a)) * svpc_pkg::PROD_W'($signed(req_i.b));
    norm_q <= req_i.norm;
  end

  // arithmetic shift gives rounding toward minus infinity
  always_comb begin
    shifted   = norm_q ? (prod_q >>> svpc_pkg::NORMAL_FRAC_BITS)
                       : (prod_q >>> svpc_pkg::FRAC_BITS);
    hi        = shifted[svpc_pkg::PROD_W-1:svpc_pkg::WORD_W-1];
    res_o.ovf = !((&hi) || (~|hi));
    if (res_o.ovf) begin
      res_o.val = shifted[svpc_pkg::PROD_W-1] ? svpc_pkg::WORD_MIN : svpc_pkg::WORD_MAX;
    end else begin
      res_o.val = shifted[svpc_pkg::WORD_W-1:0];
    end
  end

endmodule

// ----- src/svpc_seq.sv -----
// step sequencer: load, product issue, state update, payoff
module svpc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               path_end_i,
  input  logic               out_free_i,
  output svpc_pkg::seq_ctl_t ctl_o
);

  svpc_pkg::seq_state_e              state_q, state_d;
  logic [svpc_pkg::OPC_W-1:0]        cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svpc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      svpc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = svpc_pkg::ST_LOAD;
      end
      svpc_pkg::ST_LOAD: begin
        state_d = svpc_pkg::ST_RUN;
        cnt_d   = '0;
      end
      svpc_pkg::ST_RUN: begin
        if (cnt_q == svpc_pkg::RUN_LAST) begin
          state_d = svpc_pkg::ST_UPDATE;
        end else begin
          cnt_d = cnt_q + svpc_pkg::OPC_ONE;
        end
      end
      svpc_pkg::ST_UPDATE: begin
        state_d = path_end_i ? svpc_pkg::ST_FINISH : svpc_pkg::ST_IDLE;
      end
      svpc_pkg::ST_FINISH: begin
        if (out_free_i) state_d = svpc_pkg::ST_IDLE;
      end
      default: state_d = svpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o        = '0;
    ctl_o.op_cnt = cnt_q;
    case (state_q)
      svpc_pkg::ST_IDLE:   ctl_o.in_ready  = 1'b1;
      svpc_pkg::ST_LOAD:   ctl_o.load_en   = 1'b1;
      svpc_pkg::ST_RUN:    ctl_o.run_en    = 1'b1;
      svpc_pkg::ST_UPDATE: ctl_o.update_en = 1'b1;
      svpc_pkg::ST_FINISH: ctl_o.finish_en = out_free_i;
      default: ;
    endcase
  end

endmodule

// ----- src/stoch_vol_path_call_payoff.sv -----
// top level of the stochastic volatility path call payoff engine
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   normal_price, normal_vol, normal_mean (Q4.12)
//  out_o    out  valid/ready   path_payoff, payoff_total, paths_done, overflow_seen
//  cfg      in   cfg_we_i      cfg_index_i, cfg_data_i (64 bits)
//
//  each item steps through accept, difference load, the run on the single
//  32x32 multiplier (nine products issued back to back, then a drain), state update
//  the last item of a path adds a payoff step, held while the previous result waits
//  ready is high only while idle; a result waits in the output register
//  reset is asynchronous and active low; no clearing pass is needed
`include "stoch_vol_path_call_payoff_assert.svh"
module stoch_vol_path_call_payoff (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [svpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [svpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  svpc_in_if.sink                          in_i,
  svpc_out_if.source                       out_o
);

  svpc_pkg::cfg_t      cfg;
  svpc_pkg::seq_ctl_t  ctl;
  svpc_pkg::mul_req_t  mul_req;
  svpc_pkg::sat_res_t  mul_res;

  // path state
  svpc_pkg::word_t     price_q, vol_q, mean_q;
  logic [svpc_pkg::STEP_W-1:0] step_q;
  logic [svpc_pkg::SUM_W-1:0]  sum_q;
  logic [svpc_pkg::CNT_W-1:0]  path_cnt_q;
  logic                ovf_q, ovf_d;

  // per-step working registers
  svpc_pkg::norm_t     n1_q, n2_q, n3_q;
  svpc_pkg::word_t     t_q, dvm_q, dmt_q;
  svpc_pkg::acc_t      acc_s_q, acc_v_q, acc_m_q;

  // output register
  logic                        out_valid_q;
  logic [svpc_pkg::PAY_W-1:0]  out_pay_q;
  logic [svpc_pkg::SUM_W-1:0]  out_sum_q;
  logic [svpc_pkg::CNT_W-1:0]  out_paths_q;
  logic                        out_ovf_q;

  logic                        in_fire;
  logic                        out_free;
  logic                        res_en;
  logic [svpc_pkg::OPC_W-1:0]  res_op;
  svpc_pkg::sat_res_t          dvm, dmt, ns, nv, nm;
  logic [svpc_pkg::STEP_W-1:0] steps_eff, step_next;
  logic                        path_end;
  logic signed [svpc_pkg::WORD_W:0] pay_raw;
  logic                        pay_clamp;
  logic [svpc_pkg::PAY_W-1:0]  pay_val;
  logic [svpc_pkg::SUM_W:0]    sum_wide;
  logic [svpc_pkg::SUM_W-1:0]  sum_next;

  svpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  svpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .path_end_i (path_end),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  svpc_mul_unit u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .res_o (mul_res)
  );

  assign in_i.ready = ctl.in_ready;
  assign in_fire    = in_i.valid && ctl.in_ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // operand select: products come out in the cycle after issue, so the chain
  // s*v -> *sqdt -> *n1 is interleaved with the independent products
  always_comb begin
    mul_req = '0;
    case (ctl.op_cnt)
      svpc_pkg::OP_SV: begin
        mul_req.a = price_q;
        mul_req.b = vol_q;
      end
      svpc_pkg::OP_SR: begin
        mul_req.a = price_q;
        mul_req.b = cfg.rdt;
      end
      svpc_pkg::OP_TSQ: begin
        mul_req.a = t_q;
        mul_req.b = cfg.sqdt;
      end
      svpc_pkg::OP_ADV: begin
        mul_req.a = cfg.adt;
        mul_req.b = dvm_q;
      end
      svpc_pkg::OP_TN1: begin
        mul_req.a    = t_q;
        mul_req.b    = svpc_pkg::norm_to_word(n1_q);
        mul_req.norm = 1'b1;
      end
      svpc_pkg::OP_KRHO: begin
        mul_req.a    = cfg.krho;
        mul_req.b    = svpc_pkg::norm_to_word(n1_q);
        mul_req.norm = 1'b1;
      end
      svpc_pkg::OP_KNOISE: begin
        mul_req.a    = cfg.knoise;
        mul_req.b    = svpc_pkg::norm_to_word(n2_q);
        mul_req.norm = 1'b1;
      end
      svpc_pkg::OP_A0DM: begin
        mul_req.a = cfg.a0dt;
        mul_req.b = dmt_q;
      end
      svpc_pkg::OP_K0N3: begin
        mul_req.a    = cfg.k0sdt;
        mul_req.b    = svpc_pkg::norm_to_word(n3_q);
        mul_req.norm = 1'b1;
      end
      default: ;
    endcase
  end

  // first issue cycle has no product back yet
  assign res_en = ctl.run_en && (ctl.op_cnt != svpc_pkg::OP_SV);
  assign res_op = ctl.op_cnt - svpc_pkg::OPC_ONE;

  // saturated differences feeding the reversion products
  assign dvm = svpc_pkg::sat_acc(svpc_pkg::word_to_acc(vol_q) - svpc_pkg::word_to_acc(mean_q));
  assign dmt = svpc_pkg::sat_acc(svpc_pkg::word_to_acc(mean_q)
                                 - svpc_pkg::word_to_acc(cfg.mtarget));

  // exact update sums, saturated once
  assign ns = svpc_pkg::sat_acc(acc_s_q);
  assign nv = svpc_pkg::sat_acc(acc_v_q);
  assign nm = svpc_pkg::sat_acc(acc_m_q);

  // a zero step count behaves as one; a count lowered mid-path ends it now
  assign steps_eff = (cfg.steps == '0) ? svpc_pkg::STEP_W'(1) : cfg.steps;
  assign step_next = step_q + svpc_pkg::STEP_W'(1);
  assign path_end  = !((step_next < steps_eff) && (step_next != '0));

  // payoff from the stored final price
  assign pay_raw   = {price_q[svpc_pkg::WORD_W-1], price_q}
                   - {cfg.strike[svpc_pkg::WORD_W-1], cfg.strike};
  assign pay_clamp = !pay_raw[svpc_pkg::WORD_W] && pay_raw[svpc_pkg::WORD_W-1];
  always_comb begin
    if (pay_raw[svpc_pkg::WORD_W]) begin
      pay_val = '0;
    end else if (pay_clamp) begin
      pay_val = '1;
    end else begin
      pay_val = pay_raw[svpc_pkg::PAY_W-1:0];
    end
  end
  assign sum_wide = {1'b0, sum_q} + {{(svpc_pkg::SUM_W+1-svpc_pkg::PAY_W){1'b0}}, pay_val};
  assign sum_next = sum_wide[svpc_pkg::SUM_W] ? '1 : sum_wide[svpc_pkg::SUM_W-1:0];

  // sticky saturation flag of the current path
  always_comb begin
    ovf_d = ovf_q;
    if (in_fire && (step_q == '0)) ovf_d = 1'b0;
    if (ctl.load_en)   ovf_d = ovf_q | dvm.ovf | dmt.ovf;
    if (res_en)        ovf_d = ovf_q | mul_res.ovf;
    if (ctl.update_en) ovf_d = ovf_q | ns.ovf | nv.ovf | nm.ovf;
    if (ctl.finish_en) ovf_d = ovf_q | pay_clamp;
  end

  // control and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      sum_q       <= '0;
      path_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
      if (ctl.update_en) begin
        step_q <= path_end ? '0 : step_next;
      end
      if (ctl.finish_en) begin
        sum_q       <= sum_next;
        path_cnt_q  <= path_cnt_q + svpc_pkg::CNT_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      n1_q <= in_i.normal_price;
      n2_q <= in_i.normal_vol;
      n3_q <= in_i.normal_mean;
      // start values are sampled at the first step of a path
      if (step_q == '0) begin
        price_q <= cfg.init_price;
        vol_q   <= cfg.init_vol;
        mean_q  <= cfg.init_mean;
      end
    end
    if (ctl.load_en) begin
      dvm_q   <= dvm.val;
      dmt_q   <= dmt.val;
      acc_s_q <= svpc_pkg::word_to_acc(price_q);
      acc_v_q <= svpc_pkg::word_to_acc(vol_q);
      acc_m_q <= svpc_pkg::word_to_acc(mean_q);
    end
    if (res_en) begin
      case (res_op)
        svpc_pkg::OP_SV, svpc_pkg::OP_TSQ: t_q <= mul_res.val;
        svpc_pkg::OP_SR, svpc_pkg::OP_TN1:
          acc_s_q <= acc_s_q + svpc_pkg::word_to_acc(mul_res.val);
        svpc_pkg::OP_ADV:
          acc_v_q <= acc_v_q - svpc_pkg::word_to_acc(mul_res.val);
        svpc_pkg::OP_KRHO, svpc_pkg::OP_KNOISE:
          acc_v_q <= acc_v_q + svpc_pkg::word_to_acc(mul_res.val);
        svpc_pkg::OP_A0DM:
          acc_m_q <= acc_m_q - svpc_pkg::word_to_acc(mul_res.val);
        svpc_pkg::OP_K0N3:
          acc_m_q <= acc_m_q + svpc_pkg::word_to_acc(mul_res.val);
        default: ;
      endcase
    end
    if (ctl.update_en) begin
      price_q <= ns.val;
      vol_q   <= nv.val;
      mean_q  <= nm.val;
    end
    if (ctl.finish_en) begin
      out_pay_q   <= pay_val;
      out_sum_q   <= sum_next;
      out_paths_q <= path_cnt_q + svpc_pkg::CNT_W'(1);
      out_ovf_q   <= ovf_q | pay_clamp;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.path_payoff   = out_pay_q;
  assign out_o.payoff_total  = out_sum_q;
  assign out_o.paths_done    = out_paths_q;
  assign out_o.overflow_seen = out_ovf_q;

  // an accepted item keeps the block busy for the following cycle
  `SVPC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_i.ready, "ready after accept")
  // a finished path shows up in the output register with the next count
  `SVPC_ASSERT_NXT(a_result_loaded, clk_i, rst_ni, ctl.finish_en, out_valid_q && (out_paths_q == $past(path_cnt_q) + 32'd1), "result not loaded")
  // the payoff total never falls
  `SVPC_ASSERT_NXT(a_sum_monotonic, clk_i, rst_ni, ctl.finish_en, sum_q >= $past(sum_q), "payoff total fell")
  // the state update follows the last drain cycle only
  `SVPC_ASSERT_IMP(a_update_after_run, clk_i, rst_ni, ctl.update_en, ctl.op_cnt == svpc_pkg::RUN_LAST, "early update")

endmodule

// ----- tb/tb_stoch_vol_path_call_payoff.sv -----
// testbench of the stochastic volatility path call payoff engine
`timescale 1ns / 1ps

module tb_stoch_vol_path_call_payoff;

  // run length guard: the limit lies well above the slowest correct run
  localparam int     CYCLE_LIMIT   = 600000;
  // cycles allowed for an item with no result to leave the block (one step plus margin)
  localparam int     SETTLE_CYCLES = 32;
  localparam int     RANDOM_PHASES = 17;
  localparam int     PHASE_ITEMS   = 100;
  localparam int     CALM_PHASES   = 3;
  localparam int     MAX_PRINTED   = 60;
  localparam longint W_HI          = 64'sd2147483647;
  localparam longint W_LO          = -64'sd2147483648;
  localparam longint PAY_LIM       = 64'sh7FFF_FFFF;
  localparam longint SUM_LIM       = 64'sh0000_FFFF_FFFF_FFFF;

  // one expected path result
  typedef struct {
    logic [svpc_pkg::PAY_W-1:0] payoff;
    logic [svpc_pkg::SUM_W-1:0] total;
    logic [svpc_pkg::CNT_W-1:0] count;
    logic                       ovf;
  } path_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [svpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [svpc_pkg::CFG_DATA_W-1:0] cfg_data;

  svpc_in_if  in_if ();
  svpc_out_if out_if ();

  stoch_vol_path_call_payoff i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the register file and of the path state, as the block should hold them
  logic [svpc_pkg::CFG_DATA_W-1:0] cfg_shadow [8];
  longint                          sv_price;
  longint                          sv_vol;
  longint                          sv_mean;
  logic [svpc_pkg::STEP_W-1:0]     step_cnt;
  longint                          payoff_acc;
  logic [svpc_pkg::CNT_W-1:0]      path_cnt;
  logic                            path_ovf;

  path_result_t pending_paths [$];
  path_result_t check_want;

  bit no_idle;
  int err_cnt;
  int items_sent;
  int results_seen;
  int cfg_phases;
  int cycle_cnt;

  // ---------------------------------------------------------------------------
  // fixed-point arithmetic of one Euler step
  // ---------------------------------------------------------------------------

  function automatic longint sword(logic [svpc_pkg::WORD_W-1:0] w);
    return longint'(signed'(w));
  endfunction

  // clamp to signed 32 bits, noting any clipping for the current path
  function automatic longint sat_word(longint x);
    if (x > W_HI) begin
      path_ovf = 1'b1;
      return W_HI;
    end
    if (x < W_LO) begin
      path_ovf = 1'b1;
      return W_LO;
    end
    return x;
  endfunction

  // exact product, arithmetic shift is a floor, then clamp
  function automatic longint fx_mul(longint a, longint b, int sh);
    longint p;
    p = a * b;
    return sat_word(p >>> sh);
  endfunction

  // advances the path by one step; returns 1 when the step closes the path
  function automatic bit predict_step(svpc_pkg::norm_t n1, svpc_pkg::norm_t n2,
                                      svpc_pkg::norm_t n3, output path_result_t res);
    longint      s, v, m, ns, nv, nm, t, pay;
    int unsigned steps;
    steps = 32'(cfg_shadow[svpc_pkg::REG_STEPS][svpc_pkg::STEP_W-1:0]);
    // zero steps behaves as a single step
    if (steps == 0) steps = 1;
    // start values are picked up at the first step of every path
    if (step_cnt == 0) begin
      sv_price = sword(cfg_shadow[svpc_pkg::REG_INIT_PRICE][31:0]);
      sv_vol   = sword(cfg_shadow[svpc_pkg::REG_INIT_VOL_MEAN][63:32]);
      sv_mean  = sword(cfg_shadow[svpc_pkg::REG_INIT_VOL_MEAN][31:0]);
      path_ovf = 1'b0;
    end
    s = sv_price;
    v = sv_vol;
    m = sv_mean;

    t  = fx_mul(s, v, svpc_pkg::FRAC_BITS);
    t  = fx_mul(t, sword(cfg_shadow[svpc_pkg::REG_PRICE_COEF][31:0]), svpc_pkg::FRAC_BITS);
    t  = fx_mul(t, longint'(n1), svpc_pkg::NORMAL_FRAC_BITS);
    ns = sat_word(s
         + fx_mul(s, sword(cfg_shadow[svpc_pkg::REG_PRICE_COEF][63:32]), svpc_pkg::FRAC_BITS)
         + t);

    nv = sat_word(v
         - fx_mul(sword(cfg_shadow[svpc_pkg::REG_VOL_COEF][63:32]), sat_word(v - m),
                  svpc_pkg::FRAC_BITS)
         + fx_mul(sword(cfg_shadow[svpc_pkg::REG_VOL_COEF][31:0]), longint'(n1),
                  svpc_pkg::NORMAL_FRAC_BITS)
         + fx_mul(sword(cfg_shadow[svpc_pkg::REG_VOL_NOISE][63:32]), longint'(n2),
                  svpc_pkg::NORMAL_FRAC_BITS));

    nm = sat_word(m
         - fx_mul(sword(cfg_shadow[svpc_pkg::REG_MEAN_COEF][63:32]),
                  sat_word(m - sword(cfg_shadow[svpc_pkg::REG_VOL_NOISE][31:0])),
                  svpc_pkg::FRAC_BITS)
         + fx_mul(sword(cfg_shadow[svpc_pkg::REG_MEAN_COEF][31:0]), longint'(n3),
                  svpc_pkg::NORMAL_FRAC_BITS));

    sv_price = ns;
    sv_vol   = nv;
    sv_mean  = nm;
    step_cnt = step_cnt + 1'b1;

    // a lowered step count ends the path at once
    if (step_cnt < steps && step_cnt != 0) return 1'b0;

    pay = ns - sword(cfg_shadow[svpc_pkg::REG_STRIKE][31:0]);
    if (pay < 0) pay = 0;
    if (pay > PAY_LIM) begin
      pay      = PAY_LIM;
      path_ovf = 1'b1;
    end
    payoff_acc = payoff_acc + pay;
    if (payoff_acc > SUM_LIM) payoff_acc = SUM_LIM;
    path_cnt = path_cnt + 1'b1;

    res.payoff = pay[svpc_pkg::PAY_W-1:0];
    res.total  = payoff_acc[svpc_pkg::SUM_W-1:0];
    res.count  = path_cnt;
    res.ovf    = path_ovf;
    step_cnt   = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  function automatic int rand_signed(int unsigned mag);
    return int'($urandom_range(2 * mag)) - int'(mag);
  endfunction

  // mostly plausible draws within four sigma, now and then any 16-bit pattern
  function automatic svpc_pkg::norm_t rand_normal();
    if ($urandom_range(7) == 0) return svpc_pkg::norm_t'($urandom);
    return svpc_pkg::norm_t'(rand_signed(4 << svpc_pkg::NORMAL_FRAC_BITS));
  endfunction

  // register write, only ever issued while the block is idle
  task automatic cfg_write(logic [svpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [svpc_pkg::CFG_DATA_W-1:0] data);
    logic [svpc_pkg::CFG_DATA_W-1:0] kept;
    case (idx)
      svpc_pkg::REG_INIT_PRICE, svpc_pkg::REG_STRIKE: kept = data & 64'h0000_0000_FFFF_FFFF;
      svpc_pkg::REG_STEPS:                            kept = data & 64'h0000_0000_0000_FFFF;
      default:                                        kept = data;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_shadow[idx] = kept;
    @(posedge clk_i);
  endtask

  // offer one item, wait for it to be taken, then predict what it causes
  task automatic send_item(svpc_pkg::norm_t n1, svpc_pkg::norm_t n2, svpc_pkg::norm_t n3);
    path_result_t res;
    int           gap;
    gap = 0;
    if (!no_idle && $urandom_range(2) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.normal_price <= n1;
    in_if.normal_vol   <= n2;
    in_if.normal_mean  <= n3;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (predict_step(n1, n2, n3, res)) pending_paths.push_back(res);
  endtask

  // stop sending, let every expected result come out and any last step settle
  task automatic drain_block();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_paths.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED)
      $display("%0t ns: path %0d %s: got %0h, expected %0h", $realtime, results_seen + 1,
               what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------

  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(4) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_paths.size() == 0) begin
        report_mismatch("result with none expected", 64'(out_if.paths_done), 64'd0);
      end else begin
        check_want = pending_paths.pop_front();
        if (out_if.path_payoff !== check_want.payoff)
          report_mismatch("path_payoff", 64'(out_if.path_payoff), 64'(check_want.payoff));
        if (out_if.payoff_total !== check_want.total)
          report_mismatch("payoff_total", 64'(out_if.payoff_total), 64'(check_want.total));
        if (out_if.paths_done !== check_want.count)
          report_mismatch("paths_done", 64'(out_if.paths_done), 64'(check_want.count));
        if (out_if.overflow_seen !== check_want.ovf)
          report_mismatch("overflow_seen", 64'(out_if.overflow_seen), 64'(check_want.ovf));
        results_seen++;
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_paths.size());
      $display("stoch_vol_path_call_payoff verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register values straight out of reset: flat price at the strike, every path one step
  task automatic test_reset_defaults();
    send_item(svpc_pkg::norm_t'(16'sh8000), svpc_pkg::norm_t'(16'sh7FFF),
              svpc_pkg::norm_t'(0));
    send_item(svpc_pkg::norm_t'(16'sh7FFF), svpc_pkg::norm_t'(16'sh8000),
              svpc_pkg::norm_t'(-1));
    send_item(svpc_pkg::norm_t'(0), svpc_pkg::norm_t'(0), svpc_pkg::norm_t'(16'sh8000));
    drain_block();
  endtask

  // every register but the step count at its extremes so that products, differences and sums clip
  task automatic test_saturation();
    cfg_write(svpc_pkg::REG_INIT_PRICE,    {32'hFFFF_FFFF, svpc_pkg::WORD_MAX});
    cfg_write(svpc_pkg::REG_INIT_VOL_MEAN, {svpc_pkg::WORD_MAX, svpc_pkg::WORD_MIN});
    cfg_write(svpc_pkg::REG_STRIKE,        {32'h0, svpc_pkg::WORD_MIN});
    cfg_write(svpc_pkg::REG_PRICE_COEF,    {svpc_pkg::WORD_MAX, svpc_pkg::WORD_MAX});
    cfg_write(svpc_pkg::REG_VOL_COEF,      {svpc_pkg::WORD_MAX, svpc_pkg::WORD_MIN});
    cfg_write(svpc_pkg::REG_VOL_NOISE,     {svpc_pkg::WORD_MIN, svpc_pkg::WORD_MAX});
    cfg_write(svpc_pkg::REG_MEAN_COEF,     {svpc_pkg::WORD_MIN, svpc_pkg::WORD_MAX});
    cfg_write(svpc_pkg::REG_STEPS,         64'd2);
    send_item(svpc_pkg::norm_t'(16'sh7FFF), svpc_pkg::norm_t'(16'sh8000),
              svpc_pkg::norm_t'(16'sh7FFF));
    send_item(svpc_pkg::norm_t'(16'sh8000), svpc_pkg::norm_t'(16'sh7FFF),
              svpc_pkg::norm_t'(16'sh8000));
    drain_block();
    // still state: a price far below the strike pays nothing
    cfg_write(svpc_pkg::REG_PRICE_COEF, 64'd0);
    cfg_write(svpc_pkg::REG_VOL_COEF,   64'd0);
    cfg_write(svpc_pkg::REG_VOL_NOISE,  64'd0);
    cfg_write(svpc_pkg::REG_MEAN_COEF,  64'd0);
    cfg_write(svpc_pkg::REG_STEPS,      64'd1);
    cfg_write(svpc_pkg::REG_INIT_PRICE, {32'h0, svpc_pkg::WORD_MIN});
    cfg_write(svpc_pkg::REG_STRIKE,     {32'h0, svpc_pkg::WORD_MAX});
    send_item(svpc_pkg::norm_t'(16'sh1000), svpc_pkg::norm_t'(0), svpc_pkg::norm_t'(0));
    drain_block();
    // payoff beyond 31 bits is clipped and flagged
    cfg_write(svpc_pkg::REG_INIT_PRICE, {32'h0, svpc_pkg::WORD_MAX});
    cfg_write(svpc_pkg::REG_STRIKE,     {32'h0, svpc_pkg::WORD_MIN});
    send_item(svpc_pkg::norm_t'(0), svpc_pkg::norm_t'(0), svpc_pkg::norm_t'(0));
    drain_block();
  endtask

  // a step count of zero closes every path after one step
  task automatic test_zero_steps();
    cfg_write(svpc_pkg::REG_INIT_PRICE, {32'h0, 32'h0003_0000});
    cfg_write(svpc_pkg::REG_STRIKE,     {32'h0, 32'h0001_8000});
    cfg_write(svpc_pkg::REG_STEPS,      64'hFFFF_FFFF_FFFF_0000);
    send_item(svpc_pkg::norm_t'(16'sh0800), svpc_pkg::norm_t'(16'shF800),
              svpc_pkg::norm_t'(16'sh0400));
    send_item(svpc_pkg::norm_t'(16'shF000), svpc_pkg::norm_t'(16'sh1000),
              svpc_pkg::norm_t'(16'shFC00));
    drain_block();
  endtask

  // new start values written mid-path only apply from the following path
  task automatic test_start_values_mid_path();
    cfg_write(svpc_pkg::REG_INIT_VOL_MEAN, {32'h0000_4000, 32'h0000_2000});
    cfg_write(svpc_pkg::REG_PRICE_COEF,    {32'h0000_0100, 32'h0000_1000});
    cfg_write(svpc_pkg::REG_STEPS,         64'd3);
    send_item(svpc_pkg::norm_t'(16'sh0C00), svpc_pkg::norm_t'(16'sh0400),
              svpc_pkg::norm_t'(16'shF400));
    drain_block();
    cfg_write(svpc_pkg::REG_INIT_PRICE, {32'h0, 32'h0005_0000});
    cfg_write(svpc_pkg::REG_STRIKE,     {32'h0, 32'h0002_0000});
    repeat (5) send_item(rand_normal(), rand_normal(), rand_normal());
    drain_block();
  endtask

  // longest step count, then lowered below the steps already taken
  task automatic test_steps_lowered();
    cfg_write(svpc_pkg::REG_STEPS, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (3) send_item(rand_normal(), rand_normal(), rand_normal());
    drain_block();
    cfg_write(svpc_pkg::REG_STEPS, 64'd2);
    send_item(rand_normal(), rand_normal(), rand_normal());
    drain_block();
  endtask

  // a fresh register setting: mostly plausible market numbers, sometimes any bit pattern
  task automatic randomise_config(bit wild);
    int unsigned price;
    if (wild) begin
      cfg_write(svpc_pkg::REG_INIT_PRICE,    {$urandom, $urandom});
      cfg_write(svpc_pkg::REG_INIT_VOL_MEAN, {$urandom, $urandom});
      cfg_write(svpc_pkg::REG_STRIKE,        {$urandom, $urandom});
      cfg_write(svpc_pkg::REG_PRICE_COEF,    {$urandom, $urandom});
      cfg_write(svpc_pkg::REG_VOL_COEF,      {$urandom, $urandom});
      cfg_write(svpc_pkg::REG_VOL_NOISE,     {$urandom, $urandom});
      cfg_write(svpc_pkg::REG_MEAN_COEF,     {$urandom, $urandom});
    end else begin
      price = $urandom_range(1 << 16, 100 << 16);
      cfg_write(svpc_pkg::REG_INIT_PRICE, {32'h0, price});
      cfg_write(svpc_pkg::REG_INIT_VOL_MEAN,
                {32'($urandom_range(1 << 16)), 32'($urandom_range(1 << 16))});
      cfg_write(svpc_pkg::REG_STRIKE, {32'h0, 32'(int'(price) + rand_signed(price / 4))});
      cfg_write(svpc_pkg::REG_PRICE_COEF,
                {32'(rand_signed(1 << 10)), 32'($urandom_range(1 << 15))});
      cfg_write(svpc_pkg::REG_VOL_COEF,
                {32'($urandom_range(1 << 13)), 32'(rand_signed(1 << 13))});
      cfg_write(svpc_pkg::REG_VOL_NOISE,
                {32'($urandom_range(1 << 13)), 32'($urandom_range(1 << 16))});
      cfg_write(svpc_pkg::REG_MEAN_COEF,
                {32'($urandom_range(1 << 13)), 32'($urandom_range(1 << 13))});
    end
    // short paths keep results frequent; a longer one now and then, zero rarely
    case ($urandom_range(9))
      0:       cfg_write(svpc_pkg::REG_STEPS, 64'd0);
      1:       cfg_write(svpc_pkg::REG_STEPS, 64'($urandom_range(10, 40)));
      default: cfg_write(svpc_pkg::REG_STEPS, 64'($urandom_range(1, 6)));
    endcase
    cfg_phases++;
  endtask

  // random item streams under a series of settings; the last phases run without idling
  task automatic test_random_paths();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      no_idle = (ph >= RANDOM_PHASES - CALM_PHASES);
      randomise_config($urandom_range(3) == 0);
      repeat (PHASE_ITEMS) send_item(rand_normal(), rand_normal(), rand_normal());
      drain_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= svpc_pkg::REG_INIT_PRICE;
    cfg_data           <= '0;
    in_if.valid        <= 1'b0;
    in_if.normal_price <= '0;
    in_if.normal_vol   <= '0;
    in_if.normal_mean  <= '0;
    no_idle      = 1'b0;
    err_cnt      = 0;
    items_sent   = 0;
    results_seen = 0;
    cfg_phases   = 0;
    // register file and path state after reset
    foreach (cfg_shadow[i]) cfg_shadow[i] = '0;
    cfg_shadow[svpc_pkg::REG_INIT_PRICE] = 64'(1 << svpc_pkg::FRAC_BITS);
    cfg_shadow[svpc_pkg::REG_STRIKE]     = 64'(1 << svpc_pkg::FRAC_BITS);
    cfg_shadow[svpc_pkg::REG_STEPS]      = 64'd1;
    sv_price   = 1 << svpc_pkg::FRAC_BITS;
    sv_vol     = 0;
    sv_mean    = 0;
    step_cnt   = '0;
    payoff_acc = 0;
    path_cnt   = '0;
    path_ovf   = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_saturation();
    test_zero_steps();
    test_start_values_mid_path();
    test_steps_lowered();
    test_random_paths();

    $display("%0d items sent, %0d path results checked, %0d random register settings",
             items_sent, results_seen, cfg_phases);
    $display("covered reset values, clipping, zero and lowered step counts, start reloads");
    if (err_cnt == 0) begin
      $display("stoch_vol_path_call_payoff verification clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("stoch_vol_path_call_payoff verification failed");
    end
    $finish;
  end

endmodule
